// ----- rtl/core/bounded_stack_state_machine_unit_assert.svh -----
// Assertion macros used by the stack controller, bssm_ctrl.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef BOUNDED_STACK_STATE_MACHINE_UNIT_ASSERT_SVH
`define BOUNDED_STACK_STATE_MACHINE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define BSSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: same-cycle check failed");

// Next-cycle implication.
`define BSSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: next-cycle check failed");

`endif

// ----- rtl/core/bssm_pkg.sv -----
`default_nettype none

package bssm_pkg;

  // Stack geometry.
  localparam int unsigned DEPTH  = 8;
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  // Field widths.
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned WORD_W      = 32;
  localparam int unsigned STATUS_W    = 3;
  localparam int unsigned ITEM_CNT_W  = 4;
  localparam int unsigned IN_TDATA_W  = 40;
  localparam int unsigned OUT_TDATA_W = 48;

  // Command codes.
  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_POP   = 2'd2,
    CMD_PEEK  = 2'd3
  } cmd_t;

  // Status machine states, also reported as the status field.
  typedef enum logic [STATUS_W-1:0] {
    MODE_UNINIT = 3'd0,
    MODE_EMPTY  = 3'd1,
    MODE_READY  = 3'd2,
    MODE_FULL   = 3'd3,
    MODE_ERROR  = 3'd4
  } mode_t;

  // Access request from the controller to the word storage.
  typedef struct packed {
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [WORD_W-1:0] wr_data;
    logic [ADDR_W-1:0] rd_addr;
  } store_req_t;

  // One result beat; the last field of the struct sits in the lowest bits.
  typedef struct packed {
    logic [ITEM_CNT_W-1:0] item_count;
    logic [STATUS_W-1:0]   status;
    logic                  read_valid;
    logic [WORD_W-1:0]     read_value;
    logic                  accepted;
  } result_t;

  // Status that follows from a fill level outside the error state.
  function automatic mode_t mode_for_count(input logic [CNT_W-1:0] n);
    mode_t m;
    if (n == '0) begin
      m = MODE_EMPTY;
    end else if (n >= FULL_CNT) begin
      m = MODE_FULL;
    end else begin
      m = MODE_READY;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/core/bounded_stack_state_machine_unit.sv -----
// Bounded LIFO stack of signed 32-bit words with a five-state status machine.
// Input channel (in_*): one beat per command, cmd in in_tdata[1:0] (clear,
// push, pop, peek) and the word to push in in_tdata[33:2].
// Result channel (out_*): exactly one beat per command, in command order,
// carrying accepted, the popped or peeked word with its valid flag, the
// status after the command and the item count after the command.
// A command is taken into the input register, then executed and its result
// registered in the result register, which drives out_tvalid. Throughput is
// one command per cycle while the receiver does not stall: the stack pointer,
// the status and the top-word read are all combinational.
// When the receiver stalls, the result stays in the output register and one
// more command is still taken into the input register; after that in_tready
// drops until out_tready returns.
// A synchronous reset (rst_n low) empties both pipeline registers and puts
// the stack into the uninitialised state with a count of zero; a clear
// command is needed before pushes are allowed. Stored words are not reset.
`default_nettype none

module bounded_stack_state_machine_unit
  import bssm_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // [1:0] cmd, [33:2] push_value, [39:34] zero
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // [0] accepted, [32:1] read_value, [33] read_valid, [36:34] status,
  // [40:37] item_count, [47:41] zero
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  logic              in_valid_r;
  cmd_t              in_cmd_r;
  logic [WORD_W-1:0] in_value_r;
  logic              out_valid_r;
  result_t           out_res_r;
  logic              advance;
  logic              go;
  store_req_t        store_req;
  logic [WORD_W-1:0] top_word;
  result_t           result;

  // Pipeline flow control.
  assign advance   = !out_valid_r || out_tready;
  assign go        = in_valid_r && advance;
  assign in_tready = !in_valid_r || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_cmd_r   <= cmd_t'(in_tdata[CMD_W-1:0]);
      in_value_r <= in_tdata[CMD_W+WORD_W-1:CMD_W];
    end
  end

  // Status machine and command execution.
  bssm_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .go         (go),
    .cmd        (in_cmd_r),
    .push_value (in_value_r),
    .top_word   (top_word),
    .store_req  (store_req),
    .result     (result)
  );

  // Word storage.
  bssm_store u_store (
    .clk     (clk),
    .req     (store_req),
    .rd_data (top_word)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_res_r);

endmodule

`default_nettype wire

// ----- rtl/core/bssm_store.sv -----
`default_nettype none

module bssm_store
  import bssm_pkg::*;
(
  input  wire logic              clk,
  input  wire store_req_t        req,
  output logic [WORD_W-1:0]      rd_data
);

  logic [WORD_W-1:0] word_r [DEPTH];

  // Write port: one word per pushed beat.
  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      word_r[req.wr_addr] <= req.wr_data;
    end
  end

  // Read port: the current top of stack.
  assign rd_data = word_r[req.rd_addr];

endmodule

`default_nettype wire

// ----- rtl/core/bssm_ctrl.sv -----
`default_nettype none

module bssm_ctrl
  import bssm_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire cmd_t              cmd,
  input  wire logic [WORD_W-1:0] push_value,
  input  wire logic [WORD_W-1:0] top_word,
  output store_req_t             store_req,
  output result_t                result
);

  `include "bounded_stack_state_machine_unit_assert.svh"

  mode_t            mode_r, mode_nxt;
  logic [CNT_W-1:0] fill_count_r, fill_count_nxt;

  // Status and fill level registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_UNINIT;
      fill_count_r <= '0;
    end else begin
      mode_r       <= mode_nxt;
      fill_count_r <= fill_count_nxt;
    end
  end

  // Command decode, next state and the result of the beat in flight.
  always_comb begin
    logic             accepted;
    logic             rd_valid;
    mode_t            m;
    logic [CNT_W-1:0] n;
    accepted          = 1'b1;
    rd_valid          = 1'b0;
    m                 = mode_r;
    n                 = fill_count_r;
    store_req.wr_en   = 1'b0;
    store_req.wr_addr = fill_count_r[ADDR_W-1:0];
    store_req.wr_data = push_value;
    store_req.rd_addr = ADDR_W'(fill_count_r - 1'b1);

    if (mode_r == MODE_ERROR && cmd != CMD_CLEAR) begin
      accepted = 1'b0;
    end else begin
      case (cmd)
        CMD_CLEAR: begin
          n = '0;
          m = MODE_EMPTY;
        end
        CMD_PUSH: begin
          if (mode_r == MODE_UNINIT || fill_count_r >= FULL_CNT) begin
            m = MODE_ERROR;
          end else begin
            store_req.wr_en = go;
            n = fill_count_r + 1'b1;
            m = mode_for_count(n);
          end
        end
        CMD_POP, CMD_PEEK: begin
          if (mode_r == MODE_UNINIT || fill_count_r == '0) begin
            m = MODE_ERROR;
          end else begin
            rd_valid = 1'b1;
            if (cmd == CMD_POP) begin
              n = fill_count_r - 1'b1;
              m = mode_for_count(n);
            end
          end
        end
        default: begin
          m = mode_r;
        end
      endcase
    end

    // State only moves when a beat leaves the input register.
    mode_nxt       = go ? m : mode_r;
    fill_count_nxt = go ? n : fill_count_r;

    result.accepted   = accepted;
    result.read_valid = rd_valid;
    result.read_value = rd_valid ? top_word : '0;
    result.status     = m;
    result.item_count = ITEM_CNT_W'(n);
  end

  // The fill level agrees with the status outside the error state.
  `BSSM_ASSERT_NOW(a_uninit_empty, mode_r == MODE_UNINIT, fill_count_r == '0)
  `BSSM_ASSERT_NOW(a_empty_zero, mode_r == MODE_EMPTY, fill_count_r == '0)
  `BSSM_ASSERT_NOW(a_full_count, mode_r == MODE_FULL, fill_count_r == FULL_CNT)
  // A rejected command in error changes nothing.
  `BSSM_ASSERT_NEXT(a_error_sticky, go && mode_r == MODE_ERROR && cmd != CMD_CLEAR,
    mode_r == MODE_ERROR && $stable(fill_count_r))
  // A word is only returned by an accepted command, and never by a push.
  `BSSM_ASSERT_NOW(a_read_ok, result.read_valid,
    result.accepted && !store_req.wr_en && fill_count_r != '0)

endmodule

`default_nettype wire
